// File: sv/assert_macros.svh
// Assertion macros for the RTL; used by overlay_layer_negotiator.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/oln_pkg.sv
// Types and constants for the overlay layer negotiator.
// Used by oln_busy and overlay_layer_negotiator; depends on nothing.
package oln_pkg;

  localparam int unsigned NUM_LAYERS      = 4;
  localparam int unsigned VRAM_BLOCKS     = 8;
  localparam int unsigned PICKABLE_BLOCKS = 4;

  localparam logic [7:0] SHOW_FRAMES_RST     = 8'd180;
  localparam logic [7:0] FADE_WAIT_LIMIT_RST = 8'd90;

  localparam logic [1:0] MODE_FADE_IN  = 2'b01;
  localparam logic [1:0] MODE_FADE_OUT = 2'b10;

  localparam logic REG_SHOW_FRAMES = 1'b0;
  localparam logic REG_FADE_WAIT   = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_SHOW       = 3'd1,
    ACT_HOLD       = 3'd2,
    ACT_HIDE_EXP   = 3'd3,
    ACT_HIDE_EVICT = 3'd4,
    ACT_DENY_TEXT  = 3'd5,
    ACT_DENY_LAYER = 3'd6,
    ACT_DENY_BLOCK = 3'd7
  } action_t;

  typedef logic [VRAM_BLOCKS-1:0] blk_mask_t;

  typedef struct packed {
    logic [31:0] unlock_count;
    logic [31:0] display_ctrl;
    logic [15:0] layer0_ctrl;
    logic [15:0] layer1_ctrl;
    logic [15:0] layer2_ctrl;
    logic [15:0] layer3_ctrl;
    logic [15:0] brightness_ctrl;
    logic        text_present;
  } in_word_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  layer_sel;
    logic [1:0]  block_sel;
    logic [15:0] layer_ctrl_write;
    logic        clear_enable;
    logic [7:0]  status_byte;
    logic [31:0] show_total;
    logic [31:0] deny_total;
    logic [31:0] evict_total;
    logic [31:0] deny_no_layer_total;
  } out_word_t;

  // Overlay control word: char base = block, map base = block*8+2.
  function automatic logic [15:0] overlay_word(input logic [1:0] b);
    overlay_word = (16'({b, 3'b010}) << 8) | (16'(b) << 2);
  endfunction

  function automatic logic fade_active(input logic [15:0] br);
    fade_active = (br[15:14] == MODE_FADE_IN || br[15:14] == MODE_FADE_OUT)
                  && (br[4:0] != 5'd0);
  endfunction

endpackage

// File: sv/oln_busy.sv
// Per-layer VRAM block usage masks from the four layer control words.
// Depends on oln_pkg.
module oln_busy (
  input  logic [15:0]        layer_ctrl [oln_pkg::NUM_LAYERS],
  output oln_pkg::blk_mask_t layer_mask [oln_pkg::NUM_LAYERS]
);

  always_comb begin
    logic [4:0] sb;
    logic [2:0] n;
    logic [5:0] sum;
    for (int i = 0; i < oln_pkg::NUM_LAYERS; i++) begin
      layer_mask[i] = '0;
      // char base past the last block is ignored
      if (!layer_ctrl[i][5]) begin
        layer_mask[i][layer_ctrl[i][4:2]] = 1'b1;
      end
      sb = layer_ctrl[i][12:8];
      unique case (layer_ctrl[i][15:14])
        2'd0:    n = 3'd1;
        2'd3:    n = 3'd4;
        default: n = 3'd2;
      endcase
      // map spans n consecutive 2K screens, 8 per block
      for (int k = 0; k < 4; k++) begin
        sum = 6'(sb) + 6'(k);
        if (3'(k) < n) begin
          layer_mask[i][sum[5:3]] = 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/overlay_layer_negotiator.sv
// Top level of the overlay layer negotiator: frame-tick decision logic,
// counters and the APB register file. Depends on oln_pkg, oln_busy, assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one word per video frame tick
//    carrying the unlock count, display control, four layer controls,
//    brightness and the text-present flag.
//  - Output channel (out_valid/out_stall/out_data): exactly one result word per
//    input word, in order: action, layer/block, control word to write,
//    status byte and the four running counters.
//  - The result word is registered: it is in the output register at the edge
//    after acceptance. Throughput is one word per cycle while out_stall is low;
//    the whole decision is a single combinational pass over the registered state.
//  - When the receiver stalls, the result holds in the output register and
//    in_stall rises so no further word is taken until the result is taken.
//  - Reset clears all state and counters and loads show_frames = 180 and
//    fade_wait_limit = 90. The first word after reset only syncs the count.
//  - APB registers: 0x0 show_frames, 0x4 fade_wait_limit (8 bits each).
//    Write them only while the block is idle.
`include "assert_macros.svh"

module overlay_layer_negotiator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  oln_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output oln_pkg::out_word_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // config registers
  logic [7:0] show_frames_r, fade_wait_r;

  // state
  logic        synced_r, synced_nxt;
  logic [7:0]  frames_r, frames_nxt;
  logic [31:0] last_r, last_nxt;
  logic        owed_r, owed_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic [1:0]  held_layer_r, held_layer_nxt;
  logic [1:0]  held_block_r, held_block_nxt;
  logic [15:0] saved_ctrl_r, saved_ctrl_nxt;
  logic        saved_en_r, saved_en_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [31:0] cnt_show_r, cnt_show_nxt;
  logic [31:0] cnt_deny_r, cnt_deny_nxt;
  logic [31:0] cnt_evict_r, cnt_evict_nxt;
  logic [31:0] cnt_nolayer_r, cnt_nolayer_nxt;

  logic               out_valid_r;
  oln_pkg::out_word_t out_data_r, out_data_nxt;

  logic in_fire, out_fire, cfg_wr;

  logic [15:0]        layer_ctrl [oln_pkg::NUM_LAYERS];
  oln_pkg::blk_mask_t layer_mask [oln_pkg::NUM_LAYERS];

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = {24'd0, (paddr[2] == oln_pkg::REG_FADE_WAIT) ? fade_wait_r : show_frames_r};

  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign layer_ctrl[0] = in_data.layer0_ctrl;
  assign layer_ctrl[1] = in_data.layer1_ctrl;
  assign layer_ctrl[2] = in_data.layer2_ctrl;
  assign layer_ctrl[3] = in_data.layer3_ctrl;

  oln_busy u_busy (
    .layer_ctrl (layer_ctrl),
    .layer_mask (layer_mask)
  );

  always_comb begin
    logic [7:0]         fr_e, wt_e;
    logic [31:0]        last_e;
    logic               owed_e, fade, l_found, b_found, evicted;
    logic [31:0]        cs_e, cd_e, ce_e, cn_e;
    logic [1:0]         l_pick, b_pick;
    oln_pkg::blk_mask_t busy_held, busy_pick;
    logic [7:0]         fr_dec;

    // first tick: sync count and clear run state
    fr_e   = synced_r ? frames_r : 8'd0;
    wt_e   = synced_r ? wait_r : 8'd0;
    owed_e = synced_r && owed_r;
    last_e = synced_r ? last_r : in_data.unlock_count;
    cs_e   = synced_r ? cnt_show_r : 32'd0;
    cd_e   = synced_r ? cnt_deny_r : 32'd0;
    ce_e   = synced_r ? cnt_evict_r : 32'd0;
    cn_e   = synced_r ? cnt_nolayer_r : 32'd0;

    fade = oln_pkg::fade_active(in_data.brightness_ctrl);

    l_found = 1'b0;
    l_pick  = 2'd0;
    for (int l = 0; l < oln_pkg::NUM_LAYERS; l++) begin
      if (!l_found && !in_data.display_ctrl[8 + l]) begin
        l_found = 1'b1;
        l_pick  = 2'(l);
      end
    end

    busy_held = '0;
    busy_pick = '0;
    for (int i = 0; i < oln_pkg::NUM_LAYERS; i++) begin
      if (2'(i) != held_layer_r) busy_held = busy_held | layer_mask[i];
      if (2'(i) != l_pick)       busy_pick = busy_pick | layer_mask[i];
    end

    b_found = 1'b0;
    b_pick  = 2'd0;
    for (int b = 0; b < oln_pkg::PICKABLE_BLOCKS; b++) begin
      if (!b_found && !busy_pick[b]) begin
        b_found = 1'b1;
        b_pick  = 2'(b);
      end
    end

    evicted = busy_held[3'(held_block_r)];
    fr_dec  = fr_e - 8'd1;

    synced_nxt      = 1'b1;
    frames_nxt      = fr_e;
    last_nxt        = last_e;
    owed_nxt        = owed_e;
    wait_nxt        = wt_e;
    held_layer_nxt  = held_layer_r;
    held_block_nxt  = held_block_r;
    saved_ctrl_nxt  = saved_ctrl_r;
    saved_en_nxt    = saved_en_r;
    status_nxt      = {owed_e, status_r[6:0]};
    cnt_show_nxt    = cs_e;
    cnt_deny_nxt    = cd_e;
    cnt_evict_nxt   = ce_e;
    cnt_nolayer_nxt = cn_e;

    out_data_nxt                  = '0;
    out_data_nxt.action           = oln_pkg::ACT_NONE;

    priority if (fr_e != 8'd0) begin
      out_data_nxt.layer_sel = held_layer_r;
      out_data_nxt.block_sel = held_block_r;
      if (evicted) begin
        cnt_evict_nxt       = ce_e + 32'd1;
        frames_nxt          = 8'd0;
        out_data_nxt.action = oln_pkg::ACT_HIDE_EVICT;
      end else begin
        frames_nxt          = fr_dec;
        out_data_nxt.action = (fr_dec == 8'd0) ? oln_pkg::ACT_HIDE_EXP : oln_pkg::ACT_HOLD;
      end
      if (out_data_nxt.action == oln_pkg::ACT_HOLD) begin
        out_data_nxt.layer_ctrl_write = oln_pkg::overlay_word(held_block_r);
      end else begin
        out_data_nxt.layer_ctrl_write = saved_ctrl_r;
        out_data_nxt.clear_enable     = !saved_en_r;
      end
    end else if (owed_e) begin
      if (fade && wt_e < fade_wait_r) begin
        wait_nxt = wt_e + 8'd1;
      end else begin
        owed_nxt = 1'b0;
        wait_nxt = 8'd0;
        priority if (!in_data.text_present) begin
          cnt_deny_nxt        = cd_e + 32'd1;
          out_data_nxt.action = oln_pkg::ACT_DENY_TEXT;
        end else if (!l_found) begin
          cnt_deny_nxt        = cd_e + 32'd1;
          cnt_nolayer_nxt     = cn_e + 32'd1;
          out_data_nxt.action = oln_pkg::ACT_DENY_LAYER;
        end else if (!b_found) begin
          cnt_deny_nxt        = cd_e + 32'd1;
          out_data_nxt.action = oln_pkg::ACT_DENY_BLOCK;
        end else begin
          held_layer_nxt = l_pick;
          held_block_nxt = b_pick;
          saved_ctrl_nxt = layer_ctrl[l_pick];
          saved_en_nxt   = 1'b0;  // picked layer is the first disabled one
          status_nxt     = {1'b0, wt_e != 8'd0, fade, b_pick, l_pick,
                            in_data.display_ctrl[30]};
          frames_nxt     = show_frames_r;
          cnt_show_nxt   = cs_e + 32'd1;
          out_data_nxt.action           = oln_pkg::ACT_SHOW;
          out_data_nxt.layer_sel        = l_pick;
          out_data_nxt.block_sel        = b_pick;
          out_data_nxt.layer_ctrl_write = oln_pkg::overlay_word(b_pick);
        end
      end
    end else if (in_data.unlock_count > last_e) begin
      last_nxt = in_data.unlock_count;
      owed_nxt = 1'b1;
      wait_nxt = 8'd0;
    end else begin
      // count drop (or no change): just follow it
      last_nxt = in_data.unlock_count;
    end

    out_data_nxt.status_byte         = status_nxt;
    out_data_nxt.show_total          = cnt_show_nxt;
    out_data_nxt.deny_total          = cnt_deny_nxt;
    out_data_nxt.evict_total         = cnt_evict_nxt;
    out_data_nxt.deny_no_layer_total = cnt_nolayer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_frames_r <= oln_pkg::SHOW_FRAMES_RST;
      fade_wait_r   <= oln_pkg::FADE_WAIT_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        oln_pkg::REG_SHOW_FRAMES: show_frames_r <= pwdata[7:0];
        oln_pkg::REG_FADE_WAIT:   fade_wait_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r      <= 1'b0;
      frames_r      <= '0;
      last_r        <= '0;
      owed_r        <= 1'b0;
      wait_r        <= '0;
      held_layer_r  <= '0;
      held_block_r  <= '0;
      saved_ctrl_r  <= '0;
      saved_en_r    <= 1'b0;
      status_r      <= '0;
      cnt_show_r    <= '0;
      cnt_deny_r    <= '0;
      cnt_evict_r   <= '0;
      cnt_nolayer_r <= '0;
    end else if (in_fire) begin
      synced_r      <= synced_nxt;
      frames_r      <= frames_nxt;
      last_r        <= last_nxt;
      owed_r        <= owed_nxt;
      wait_r        <= wait_nxt;
      held_layer_r  <= held_layer_nxt;
      held_block_r  <= held_block_nxt;
      saved_ctrl_r  <= saved_ctrl_nxt;
      saved_en_r    <= saved_en_nxt;
      status_r      <= status_nxt;
      cnt_show_r    <= cnt_show_nxt;
      cnt_deny_r    <= cnt_deny_nxt;
      cnt_evict_r   <= cnt_evict_nxt;
      cnt_nolayer_r <= cnt_nolayer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_NXT(a_word_out, in_fire, out_valid_r, "accepted word produced no result")
  `ASSERT_NXT(a_held_action, in_fire && synced_r && frames_r != 8'd0,
              out_data_r.action == oln_pkg::ACT_HOLD || out_data_r.action == oln_pkg::ACT_HIDE_EXP
              || out_data_r.action == oln_pkg::ACT_HIDE_EVICT,
              "shown overlay gave a non-hold action")
  `ASSERT_NXT(a_show_count, in_fire && synced_r,
              (cnt_show_r != $past(cnt_show_r)) == (out_data_r.action == oln_pkg::ACT_SHOW),
              "show counter out of step with show action")

endmodule

// File: tb/sv/oln_result_checker.sv
// Checker for the overlay layer negotiator: tracks register writes, predicts
// each result word from the accepted input word and compares it. Depends on oln_pkg.
`timescale 1ns / 100ps

module oln_result_checker
  import oln_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_word_t  out_data,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic       pready,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output int         mismatches,
  output int         outstanding
);

  localparam logic [2:0] ADDR_SHOW = {REG_SHOW_FRAMES, 2'b00};
  localparam logic [2:0] ADDR_FADE = {REG_FADE_WAIT, 2'b00};

  // register mirror
  logic [7:0] show_frames;
  logic [7:0] fade_limit;

  // negotiation state
  logic        synced;
  logic [7:0]  frames_left;
  logic [31:0] last_count;
  logic        owed;
  logic [7:0]  wait_cnt;
  logic [1:0]  held_layer;
  logic [1:0]  held_block;
  logic [15:0] saved_ctrl;
  logic        saved_en;
  logic [7:0]  status;
  logic [31:0] show_total, deny_total, evict_total, no_layer_total;

  out_word_t pending_results[$];

  function automatic logic fading(logic [15:0] br);
    return (br[15:14] == MODE_FADE_IN || br[15:14] == MODE_FADE_OUT) && br[4:0] != 5'd0;
  endfunction

  // char base = block, map base = block*8+2
  function automatic logic [15:0] tile_map_word(logic [1:0] b);
    return {3'b000, b, 3'b010, 4'b0000, b, 2'b00};
  endfunction

  // VRAM blocks referenced by tiles or map of every layer but skip
  function automatic blk_mask_t blocks_in_use(in_word_t w, int skip);
    logic [15:0] ctl [NUM_LAYERS];
    blk_mask_t   m;
    int          n;
    int          blk;
    ctl[0] = w.layer0_ctrl;
    ctl[1] = w.layer1_ctrl;
    ctl[2] = w.layer2_ctrl;
    ctl[3] = w.layer3_ctrl;
    m = '0;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      if (i != skip) begin
        if (ctl[i][5:2] < VRAM_BLOCKS) m[ctl[i][5:2]] = 1'b1;
        n = (ctl[i][15:14] == 2'd0) ? 1 : ((ctl[i][15:14] == 2'd3) ? 4 : 2);
        for (int k = 0; k < n; k++) begin
          blk = (int'(ctl[i][12:8]) + k) / 8;
          if (blk < VRAM_BLOCKS) m[blk] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic out_word_t predict_tick(in_word_t w);
    out_word_t   r;
    blk_mask_t   busy;
    int          lay;
    int          blk;
    logic [15:0] ctl [NUM_LAYERS];
    ctl[0] = w.layer0_ctrl;
    ctl[1] = w.layer1_ctrl;
    ctl[2] = w.layer2_ctrl;
    ctl[3] = w.layer3_ctrl;
    r = '0;
    r.action = ACT_NONE;
    if (!synced) begin
      synced = 1'b1;
      frames_left = '0;
      owed = 1'b0;
      wait_cnt = '0;
      last_count = w.unlock_count;
      show_total = '0;
      deny_total = '0;
      evict_total = '0;
      no_layer_total = '0;
    end
    status[7] = owed;
    if (frames_left != 0) begin
      busy = blocks_in_use(w, held_layer);
      r.layer_sel = held_layer;
      r.block_sel = held_block;
      if (busy[held_block]) begin
        evict_total++;
        frames_left = '0;
        r.action = ACT_HIDE_EVICT;
      end else begin
        frames_left--;
        r.action = (frames_left == 0) ? ACT_HIDE_EXP : ACT_HOLD;
      end
      if (r.action == ACT_HOLD) begin
        r.layer_ctrl_write = tile_map_word(held_block);
      end else begin
        r.layer_ctrl_write = saved_ctrl;
        r.clear_enable = !saved_en;
      end
    end else if (owed) begin
      if (fading(w.brightness_ctrl) && wait_cnt < fade_limit) begin
        wait_cnt++;
      end else begin
        owed = 1'b0;
        lay = NUM_LAYERS;
        for (int l = NUM_LAYERS - 1; l >= 0; l--)
          if (!w.display_ctrl[8 + l]) lay = l;
        if (!w.text_present) begin
          deny_total++;
          r.action = ACT_DENY_TEXT;
        end else if (lay >= NUM_LAYERS) begin
          deny_total++;
          no_layer_total++;
          r.action = ACT_DENY_LAYER;
        end else begin
          busy = blocks_in_use(w, lay);
          blk = PICKABLE_BLOCKS;
          for (int b = PICKABLE_BLOCKS - 1; b >= 0; b--)
            if (!busy[b]) blk = b;
          if (blk >= PICKABLE_BLOCKS) begin
            deny_total++;
            r.action = ACT_DENY_BLOCK;
          end else begin
            held_layer = lay[1:0];
            held_block = blk[1:0];
            saved_ctrl = ctl[lay];
            saved_en = w.display_ctrl[8 + lay];
            status = {1'b0, wait_cnt != 0, fading(w.brightness_ctrl), blk[1:0], lay[1:0],
                      w.display_ctrl[30]};
            frames_left = show_frames;
            show_total++;
            r.action = ACT_SHOW;
            r.layer_sel = lay[1:0];
            r.block_sel = blk[1:0];
            r.layer_ctrl_write = tile_map_word(blk[1:0]);
          end
        end
        wait_cnt = '0;
      end
    end else if (w.unlock_count > last_count) begin
      last_count = w.unlock_count;
      owed = 1'b1;
      wait_cnt = '0;
    end else if (w.unlock_count < last_count) begin
      last_count = w.unlock_count;
    end
    r.status_byte = status;
    r.show_total = show_total;
    r.deny_total = deny_total;
    r.evict_total = evict_total;
    r.deny_no_layer_total = no_layer_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      mismatches++;
    end
  endtask

  task automatic compare_word(out_word_t exp, out_word_t got);
    check_field("action", exp.action, got.action);
    check_field("layer_sel", exp.layer_sel, got.layer_sel);
    check_field("block_sel", exp.block_sel, got.block_sel);
    check_field("layer_ctrl_write", exp.layer_ctrl_write, got.layer_ctrl_write);
    check_field("clear_enable", exp.clear_enable, got.clear_enable);
    check_field("status_byte", exp.status_byte, got.status_byte);
    check_field("show_total", exp.show_total, got.show_total);
    check_field("deny_total", exp.deny_total, got.deny_total);
    check_field("evict_total", exp.evict_total, got.evict_total);
    check_field("deny_no_layer_total", exp.deny_no_layer_total, got.deny_no_layer_total);
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      show_frames = SHOW_FRAMES_RST;
      fade_limit = FADE_WAIT_LIMIT_RST;
      synced = 1'b0;
      frames_left = '0;
      last_count = '0;
      owed = 1'b0;
      wait_cnt = '0;
      held_layer = '0;
      held_block = '0;
      saved_ctrl = '0;
      saved_en = 1'b0;
      status = '0;
      show_total = '0;
      deny_total = '0;
      evict_total = '0;
      no_layer_total = '0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_SHOW) show_frames = pwdata[7:0];
        else if (paddr == ADDR_FADE) fade_limit = pwdata[7:0];
      end
      // results first: a word leaving now belongs to an earlier input
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          compare_word(pending_results.pop_front(), out_data);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(predict_tick(in_data));
      outstanding <= pending_results.size();
    end
  end

endmodule

// File: tb/sv/tb_overlay_layer_negotiator.sv
// Top of the overlay layer negotiator testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on oln_pkg, oln_result_checker and the RTL.
`timescale 1ns / 100ps

module tb_overlay_layer_negotiator;
  import oln_pkg::*;

  localparam logic [2:0] ADDR_SHOW = {REG_SHOW_FRAMES, 2'b00};
  localparam logic [2:0] ADDR_FADE = {REG_FADE_WAIT, 2'b00};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 200;

  // quiet layer: char base past VRAM, map in block 3
  localparam logic [15:0] QUIET = 16'h1C3C;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int           mismatches;
  int           outstanding;
  int           idle_cycles = 0;
  int           stall_cycle = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [31:0]  count_now = 32'd0;

  overlay_layer_negotiator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  oln_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic in_word_t tick(logic [31:0] cnt, logic [31:0] disp, logic [15:0] l0,
                                    logic [15:0] l1, logic [15:0] l2, logic [15:0] l3,
                                    logic [15:0] br, logic txt);
    in_word_t w;
    w.unlock_count = cnt;
    w.display_ctrl = disp;
    w.layer0_ctrl = l0;
    w.layer1_ctrl = l1;
    w.layer2_ctrl = l2;
    w.layer3_ctrl = l3;
    w.brightness_ctrl = br;
    w.text_present = txt;
    return w;
  endfunction

  // mostly layers that leave blocks 0-2 free, some fully random ones
  function automatic logic [15:0] layer_word();
    logic [15:0] c;
    c = 16'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      c[5:2] = 4'($urandom_range(4, 15));
      c[12:8] = 5'($urandom_range(24, 28));
    end
    return c;
  endfunction

  function automatic in_word_t random_tick();
    logic [31:0] disp;
    logic [15:0] br;
    case ($urandom_range(0, 19))
      0, 1, 2, 3:  count_now = count_now + $urandom_range(1, 3);
      4:           count_now = count_now - $urandom_range(1, 5);
      5:           count_now = $urandom();
      default:     ;
    endcase
    disp = $urandom();
    if ($urandom_range(0, 4) == 0) disp[11:8] = 4'hF;
    br = 16'($urandom());
    if ($urandom_range(0, 9) > 2) br[15:14] = $urandom_range(0, 1) ? 2'b00 : 2'b11;
    return tick(count_now, disp, layer_word(), layer_word(), layer_word(), layer_word(), br,
                $urandom_range(0, 9) != 0);
  endfunction

  task automatic send(in_word_t w);
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // receiver stall pattern; its style is re-picked at random from stall_cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 256 == 0) stall_style <= stall_style_t'($urandom_range(0, 3));
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 9) < 3);
        STALL_PERIODIC: out_stall <= (stall_cycle % 5 < 2);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** overlay_layer_negotiator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] show_set [PHASES];
    logic [7:0] fade_set [PHASES];
    int         burst_left;
    int         gap;
    show_set = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd7, 8'd20, 8'd2};
    fade_set = '{8'd2, 8'd0, 8'd255, 8'd5, 8'd1, 8'd40, 8'd0};
    burst_left = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at the reset register values
    send(tick(32'd100, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1)); // sync only
    send(tick(32'd100, 32'h0000_0000, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'd99,  32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1)); // drop
    send(tick(32'd101, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1)); // rise
    send(tick(32'd101, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h4010, 1'b1)); // fade in
    send(tick(32'd101, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h8001, 1'b1)); // fade out
    send(tick(32'd101, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h4000, 1'b0)); // no text
    send(tick(32'd102, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'd102, 32'hFFFF_FFFF, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1)); // no layer
    send(tick(32'd103, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'd103, 32'h0000_0300, 16'h0800, 16'h1808, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'd104, 32'h0000_0300, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'd104, 32'h4000_0E00, QUIET, QUIET, QUIET, QUIET, 16'hC01F, 1'b1)); // show
    send(tick(32'hFFFF_FFFF, 32'h4000_0E00, QUIET, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'hFFFF_FFFF, 32'h4000_0E00, QUIET, QUIET, QUIET, 16'hFFFF, 16'h0000, 1'b1));
    send(tick(32'hFFFF_FFFF, 32'h4000_0E00, QUIET, 16'h0000, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'hFFFF_FFFF, 32'h0000_0700, 16'h0000, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'hFFFF_FFFF, 32'h0000_0700, 16'h0000, QUIET, QUIET, QUIET, 16'h4010, 1'b1));
    send(tick(32'hFFFF_FFFF, 32'h0000_0700, 16'h0000, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'hFFFF_FFFF, 32'h0000_0700, 16'h0000, QUIET, QUIET, QUIET, 16'hFFFF, 1'b0));
    send(tick(32'h0000_0000, 32'h0000_0700, 16'h0000, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    send(tick(32'h0000_0000, 32'h0000_0700, 16'h0000, QUIET, QUIET, QUIET, 16'h0000, 1'b1));
    count_now = 32'd0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(ADDR_SHOW, {24'd0, show_set[p]});
      write_reg(ADDR_FADE, {24'd0, fade_set[p]});
      @(posedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 24);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send(random_tick());
        burst_left--;
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** overlay_layer_negotiator: PASSED **");
    end else begin
      $display("** overlay_layer_negotiator: FAILED **");
    end
    $finish;
  end

endmodule
